### src/dfr_pkg.sv
// Shared types, constants and functions for the type-length packet deframer.
// No dependencies; imported by every module of the block.
package dfr_pkg;

   localparam int BufferBytes = 32;

   localparam logic [15:0] CrcInit       = 16'hFFFF;
   localparam logic [15:0] CrcPoly       = 16'h8408;
   localparam logic [7:0]  KeyType       = 8'h80;
   localparam logic [8:0]  FrameOverhead = 9'd4;
   localparam logic [7:0]  KeyCodeMax    = 8'd6;

   localparam logic [2:0] ActNone   = 3'd0;
   localparam logic [2:0] ActBack   = 3'd1;
   localparam logic [2:0] ActSelect = 3'd2;
   localparam logic [2:0] ActPrev   = 3'd3;
   localparam logic [2:0] ActNext   = 3'd4;
   localparam logic [2:0] ActHome   = 3'd5;

   typedef enum logic [4:0] {
      PH_TYPE    = 5'b00001,
      PH_LEN     = 5'b00010,
      PH_PAYLOAD = 5'b00100,
      PH_CRC_LO  = 5'b01000,
      PH_CRC_HI  = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [7:0] packet_type;
      logic [7:0] payload_length;
      logic [7:0] first_payload;
      logic       crc_good;
      logic [2:0] key_action;
      logic       oversize_drop;
   } result_type;

   // One byte of CRC-16/X.25, reflected, LSB first.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc;
      for (int k = 0; k < 8; k++) begin
         if (c[0] ^ data[k]) begin
            c = (c >> 1) ^ CrcPoly;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   function automatic logic [2:0] key_map(input logic [2:0] code);
      logic [2:0] act;
      case (code)
         3'd1:    act = ActBack;
         3'd2:    act = ActSelect;
         3'd3:    act = ActPrev;
         3'd4:    act = ActNext;
         3'd5:    act = ActSelect;
         3'd6:    act = ActHome;
         default: act = ActNone;
      endcase
      return act;
   endfunction

endpackage

### src/dfr_core.sv
// Packet phase sequencer, running CRC and result formation for one byte a beat.
// Depends on dfr_pkg.
module dfr_core #(
   parameter int BufBytes = dfr_pkg::BufferBytes
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          rx_byte,
   output logic                emit,
   output dfr_pkg::result_type result
);
   import dfr_pkg::*;

   localparam logic [8:0] BufLimit = 9'(BufBytes);

   phase_type   phase_ff, phase_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  length_ff, length_in;
   logic [7:0]  count_ff, count_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  first_ff, first_in;
   logic [7:0]  crc_lo_ff, crc_lo_in;

   logic        good;
   logic [2:0]  action;
   logic [8:0]  count_inc;

   assign good      = ({rx_byte, crc_lo_ff} == ~crc_ff);
   assign count_inc = {1'b0, count_ff} + 9'd1;

   always_comb begin
      action = ActNone;
      if (good && type_ff == KeyType && length_ff == 8'd1 && first_ff <= KeyCodeMax) begin
         action = key_map(first_ff[2:0]);
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      type_in   = type_ff;
      length_in = length_ff;
      count_in  = count_ff;
      crc_in    = crc_ff;
      first_in  = first_ff;
      crc_lo_in = crc_lo_ff;
      emit      = 1'b0;
      result    = '{packet_type: type_ff, payload_length: length_ff, first_payload: 8'd0,
                    crc_good: 1'b0, key_action: ActNone, oversize_drop: 1'b0};
      unique case (phase_ff)
         PH_LEN: begin
            length_in = rx_byte;
            result.payload_length = rx_byte;
            if (FrameOverhead + {1'b0, rx_byte} > BufLimit) begin
               // drop and hunt for the next type byte
               emit     = 1'b1;
               result.oversize_drop = 1'b1;
               phase_in = PH_TYPE;
               crc_in   = CrcInit;
            end else begin
               crc_in   = crc_byte(crc_ff, rx_byte);
               count_in = 8'd0;
               first_in = 8'd0;
               phase_in = (rx_byte == 8'd0) ? PH_CRC_LO : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            if (count_ff == 8'd0) begin
               first_in = rx_byte;
            end
            crc_in   = crc_byte(crc_ff, rx_byte);
            count_in = count_inc[7:0];
            if (count_inc >= {1'b0, length_ff}) begin
               phase_in = PH_CRC_LO;
            end
         end
         PH_CRC_LO: begin
            crc_lo_in = rx_byte;
            phase_in  = PH_CRC_HI;
         end
         PH_CRC_HI: begin
            emit     = 1'b1;
            result.first_payload = first_ff;
            result.crc_good      = good;
            result.key_action    = action;
            phase_in = PH_TYPE;
            crc_in   = CrcInit;
         end
         default: begin
            // type byte; unused codes land here too
            type_in   = rx_byte;
            length_in = 8'd0;
            count_in  = 8'd0;
            first_in  = 8'd0;
            crc_in    = crc_byte(CrcInit, rx_byte);
            phase_in  = PH_LEN;
         end
      endcase
      if (!accept) begin
         emit = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_TYPE;
         type_ff   <= 8'd0;
         length_ff <= 8'd0;
         count_ff  <= 8'd0;
         crc_ff    <= CrcInit;
         first_ff  <= 8'd0;
         crc_lo_ff <= 8'd0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         type_ff   <= type_in;
         length_ff <= length_in;
         count_ff  <= count_in;
         crc_ff    <= crc_in;
         first_ff  <= first_in;
         crc_lo_ff <= crc_lo_in;
      end
   end

`ifndef ASSERT_OFF
   a_emit_phase: assert property (@(posedge clock) disable iff (reset)
      emit |-> (phase_ff == PH_LEN || phase_ff == PH_CRC_HI))
      else $error("result formed outside length or CRC-high phase");

   a_drop_clean: assert property (@(posedge clock) disable iff (reset)
      (emit && result.oversize_drop) |-> (!result.crc_good && result.key_action == ActNone))
      else $error("oversize drop carries CRC or key status");

   a_key_only_good: assert property (@(posedge clock) disable iff (reset)
      (emit && result.key_action != ActNone) |->
         (result.crc_good && result.packet_type == KeyType && result.payload_length == 8'd1))
      else $error("key action on a packet that is not a good key report");

   a_crc_restart: assert property (@(posedge clock) disable iff (reset)
      emit |=> (phase_ff == PH_TYPE && crc_ff == CrcInit))
      else $error("sequencer not back to type hunt after a result");
`endif

endmodule

### src/dfr_out.sv
// Result register: holds one finished result until the consumer takes it.
// Depends on dfr_pkg.
module dfr_out (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  dfr_pkg::result_type push_data,
   output logic                space,
   output logic                out_valid,
   input  logic                out_ready,
   output dfr_pkg::result_type out_data
);
   import dfr_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   // free when empty or being drained this beat
   assign space     = !valid_ff || out_ready;
   assign valid_in  = push || (valid_ff && !out_ready);
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff <= push_data;
      end
   end

`ifndef ASSERT_OFF
   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push |-> space)
      else $error("result pushed over an undelivered result");

   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      push |=> (valid_ff && data_ff == $past(push_data)))
      else $error("pushed result not presented");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !valid_ff)
      else $error("result register not empty after reset");
`endif

endmodule

### src/crc16_key_packet_deframer.sv
// Channel  | ports                                   | direction
// req      | req_valid, req_ready, req_rx_byte       | in: one serial byte a beat
// rsp      | rsp_valid, rsp_ready, rsp_* fields      | out: one result per packet
//
// One byte is taken every cycle while req_ready is high; each byte is one pass
// through the phase sequencer, with an eight-bit CRC update on type, length and
// payload bytes. A result appears the cycle after the CRC high byte (or an oversize length).
// Synchronous reset empties the result register and returns to type hunt.
// req_ready drops only while a result waits and rsp_ready is low.
// Top level of the deframer; depends on dfr_pkg, dfr_core and dfr_out.
module crc16_key_packet_deframer #(
   parameter int BufBytes = dfr_pkg::BufferBytes
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_packet_type,
   output logic [7:0] rsp_payload_length,
   output logic [7:0] rsp_first_payload,
   output logic       rsp_crc_good,
   output logic [2:0] rsp_key_action,
   output logic       rsp_oversize_drop
);
   import dfr_pkg::*;

   logic       accept;
   logic       emit;
   logic       space;
   result_type core_result;
   result_type rsp_data;

   assign req_ready = space;
   assign accept    = req_valid && space;

   dfr_core #(
      .BufBytes (BufBytes)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_rx_byte),
      .emit    (emit),
      .result  (core_result)
   );

   dfr_out u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (emit),
      .push_data (core_result),
      .space     (space),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign rsp_packet_type    = rsp_data.packet_type;
   assign rsp_payload_length = rsp_data.payload_length;
   assign rsp_first_payload  = rsp_data.first_payload;
   assign rsp_crc_good       = rsp_data.crc_good;
   assign rsp_key_action     = rsp_data.key_action;
   assign rsp_oversize_drop  = rsp_data.oversize_drop;

endmodule
